[hdl/mh64_pkg.sv]
// shared types, constants and the multiply helper for the murmur hash unit
`timescale 1ns / 1ps
package mh64_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 18;
  localparam int unsigned FIN_SHIFT_B = 22;
  localparam int unsigned FIN_SHIFT_C = 17;
  localparam int unsigned FIN_SHIFT_D = 19;
  localparam logic [31:0] SEED_RESET  = 32'hee6b_27eb;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned PADDR_W   = 3;
  localparam logic [0:0]  REG_SEED  = 1'b0;

  typedef enum logic [1:0] {
    ITEM_NONE,
    ITEM_FULL,
    ITEM_TAIL
  } item_kind_e;

  typedef struct packed {
    logic [31:0] word;
    item_kind_e  kind;
    logic        first;
    logic        last;
    logic [30:0] length;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_KEY_MUL,
    BK_KEY_MIX,
    BK_LANE,
    BK_TAIL,
    BK_FIN0,
    BK_FIN1,
    BK_FIN2,
    BK_FIN3
  } back_state_e;

  function automatic logic [31:0] mul_m(input logic [31:0] x);
    logic [31:0] r;
    r = x * MIX_MUL;
    return r;
  endfunction

endpackage

[hdl/mh64_front.sv]
// front end: classifies an input beat by byte count and masks the tail bytes
`timescale 1ns / 1ps
module mh64_front import mh64_pkg::*; (
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic [30:0] message_length_i,
  output item_t       item_o
);

  logic [31:0] keep;
  item_kind_e  kind;

  always_comb begin
    keep = 32'h0000_0000;
    kind = ITEM_NONE;
    unique case (byte_count_i)
      3'd0: begin
        kind = ITEM_NONE;
      end
      3'd1: begin
        kind = ITEM_TAIL;
        keep = 32'h0000_00ff;
      end
      3'd2: begin
        kind = ITEM_TAIL;
        keep = 32'h0000_ffff;
      end
      3'd3: begin
        kind = ITEM_TAIL;
        keep = 32'h00ff_ffff;
      end
      default: begin
        kind = ITEM_FULL;
        keep = 32'hffff_ffff;
      end
    endcase
  end

  assign item_o.word   = data_word_i & keep;
  assign item_o.kind   = kind;
  assign item_o.first  = first_item_i;
  assign item_o.last   = last_item_i;
  assign item_o.length = message_length_i;

endmodule

[hdl/mh64_queue.sv]
// short fifo between the front end and the hash engine
`timescale 1ns / 1ps
module mh64_queue import mh64_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  empty_o
);

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/mh64_back.sv]
// hash engine: one shared multiplier steps key mix, lane update, tail mix and finalization
`timescale 1ns / 1ps
module mh64_back import mh64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] seed_i,
  input  logic        q_empty_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  back_state_e state_q, state_d;
  logic [31:0] lane_one_q, lane_two_q;
  logic        parity_q;
  logic [31:0] word_q, tmp_q, fa_q, fb_q;
  logic        last_q;
  logic        out_valid_q;
  logic [63:0] hash_q;
  logic [31:0] mul_in, mul_out;
  logic        emit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_item_i.kind)
            ITEM_FULL: state_d = BK_KEY_MUL;
            ITEM_TAIL: state_d = BK_TAIL;
            default:   state_d = q_item_i.last ? BK_FIN0 : BK_IDLE;
          endcase
        end
      end
      BK_KEY_MUL: state_d = BK_KEY_MIX;
      BK_KEY_MIX: state_d = BK_LANE;
      BK_LANE, BK_TAIL: state_d = last_q ? BK_FIN0 : BK_IDLE;
      BK_FIN0: state_d = BK_FIN1;
      BK_FIN1: state_d = BK_FIN2;
      BK_FIN2: state_d = BK_FIN3;
      BK_FIN3: begin
        if (emit) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    q_pop_o = 1'b0;
    emit    = 1'b0;
    mul_in  = word_q;
    unique case (state_q)
      BK_IDLE:    q_pop_o = !q_empty_i;
      BK_KEY_MUL: mul_in = word_q;
      BK_KEY_MIX: mul_in = tmp_q ^ (tmp_q >> MIX_SHIFT);
      BK_LANE:    mul_in = parity_q ? lane_two_q : lane_one_q;
      BK_TAIL:    mul_in = lane_two_q ^ word_q;
      BK_FIN0:    mul_in = lane_one_q ^ (lane_two_q >> FIN_SHIFT_A);
      BK_FIN1:    mul_in = lane_two_q ^ (fa_q >> FIN_SHIFT_B);
      BK_FIN2:    mul_in = fa_q ^ (fb_q >> FIN_SHIFT_C);
      BK_FIN3: begin
        mul_in = fb_q ^ (fa_q >> FIN_SHIFT_D);
        emit   = !out_valid_q || out_ready_i;
      end
      default:    mul_in = word_q;
    endcase
  end

  assign mul_out = mul_m(mul_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      lane_one_q  <= '0;
      lane_two_q  <= '0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o && q_item_i.first) begin
        lane_one_q <= seed_i ^ {1'b0, q_item_i.length};
        lane_two_q <= '0;
        parity_q   <= 1'b0;
      end
      if (state_q == BK_LANE) begin
        if (parity_q) begin
          lane_two_q <= mul_out ^ tmp_q;
        end else begin
          lane_one_q <= mul_out ^ tmp_q;
        end
        parity_q <= !parity_q;
      end
      if (state_q == BK_TAIL) begin
        lane_two_q <= mul_out;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      word_q <= q_item_i.word;
      last_q <= q_item_i.last;
    end
    if (state_q == BK_KEY_MUL || state_q == BK_KEY_MIX) begin
      tmp_q <= mul_out;
    end
    if (state_q == BK_FIN0 || state_q == BK_FIN2) begin
      fa_q <= mul_out;
    end
    if (state_q == BK_FIN1) begin
      fb_q <= mul_out;
    end
    if (emit) begin
      hash_q <= {fa_q, mul_out};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

[hdl/murmur_hash_64b_unit.sv]
// top level of the streaming 64-bit murmur hash unit
// usage:
//   input channel (in_valid_i / in_ready_o) takes one beat per 32-bit message
//   word, little-endian, with byte count, first and last flags and, on the
//   first beat, the message length in bytes
//   output channel (out_valid_o / out_ready_i) gives one 64-bit hash per
//   message, after the beat that carries the last flag
//   apb port holds the 32-bit seed at address 0, reset value 0xEE6B27EB
// flow:
//   a beat enters a two-entry queue; the engine pops it and then steps a full
//   word through key multiply, key mix and lane update, a partial word through
//   the tail mix and an empty beat through nothing, plus the finalization
//   states BK_FIN0 to BK_FIN3 on a last beat, all on one shared multiplier
//   the engine pops no new beat until it is through with the last one; later
//   beats wait in the queue
// reset: lanes, word parity, queue and output valid flag are cleared, the seed
//   returns to its reset value
// stall: a waiting hash holds in the output register while the engine goes on;
//   a second hash waits in the last finalization step and the queue fills,
//   dropping in_ready_o
`timescale 1ns / 1ps
module murmur_hash_64b_unit import mh64_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        data_word_i,
  input  logic [2:0]         byte_count_i,
  input  logic               first_item_i,
  input  logic               last_item_i,
  input  logic [30:0]        message_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        hash_value_o
);

  logic [31:0] seed_q;
  logic        reg_hit;
  item_t       front_item, queue_item;
  logic        q_full, q_empty, q_pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_SEED);
  assign prdata  = reg_hit ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      seed_q <= pwdata;
    end
  end

  mh64_front u_front (
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .first_item_i     (first_item_i),
    .last_item_i      (last_item_i),
    .message_length_i (message_length_i),
    .item_o           (front_item)
  );

  assign in_ready_o = !q_full;

  mh64_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (queue_item),
    .empty_o     (q_empty)
  );

  mh64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .q_empty_i    (q_empty),
    .q_item_i     (queue_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule

[hdl/mh64_checker.sv]
// port-level checks for the murmur hash unit and the bind that attaches them
`timescale 1ns / 1ps
module mh64_checker import mh64_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [63:0]        hash_value_o
);

  // output beat holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hash_value_o))
    else $error("hash changed while stalled");

  // seed write reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_SEED)
      ##1 (paddr[PADDR_W-1] == REG_SEED) |-> prdata == $past(pwdata))
    else $error("seed readback mismatch");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind murmur_hash_64b_unit mh64_checker u_mh64_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o)
);
